FILE: sv/bpv_pkg.sv
`timescale 1ns / 1ps

package bpv_pkg;

   localparam int unsigned CODE_W  = 8;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned SKIP_W  = 6;
   localparam int unsigned MASK_W  = 256;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [COUNT_W-1:0] COUNT_SAT     = 17'h1FFFF;
   localparam logic [COUNT_W-1:0] LIMIT_HARD    = 17'h1FFFE;
   localparam logic [SKIP_W-1:0]  PUSH_MAX_SIZE = 6'd32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VALID_MASK_0 = 3'd0,
      CSR_VALID_MASK_1 = 3'd1,
      CSR_VALID_MASK_2 = 3'd2,
      CSR_VALID_MASK_3 = 3'd3,
      CSR_PUSH_OPCODE  = 3'd4,
      CSR_MAX_CODE_LEN = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      V_OK            = 3'd0,
      V_EMPTY         = 3'd1,
      V_TOO_LONG      = 3'd2,
      V_BAD_OP        = 3'd3,
      V_PUSH_NO_SIZE  = 3'd4,
      V_BAD_PUSH_SIZE = 3'd5,
      V_PUSH_OVERRUN  = 3'd6
   } verdict_type;

   typedef struct packed {
      logic [MASK_W-1:0]  valid_mask;
      logic [CODE_W-1:0]  push_opcode;
      logic [COUNT_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic             done;
      verdict_type      verdict;
      logic [POS_W-1:0] position;
   } result_type;

endpackage

FILE: sv/bpv_if.sv
`timescale 1ns / 1ps

interface bpv_req_if;
   import bpv_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_byte;
   logic              last_byte;
   logic              empty_code;
   modport source (output valid, code_byte, last_byte, empty_code, input ready);
   modport sink (input valid, code_byte, last_byte, empty_code, output ready);
endinterface

interface bpv_rsp_if;
   import bpv_pkg::*;
   logic             valid;
   logic             ready;
   logic [2:0]       verdict;
   logic [POS_W-1:0] error_position;
   modport source (output valid, verdict, error_position, input ready);
   modport sink (input valid, verdict, error_position, output ready);
endinterface

interface bpv_csr_if;
   import bpv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/bpv_parser.sv
`timescale 1ns / 1ps

module bpv_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [bpv_pkg::CODE_W-1:0]     code_byte,
   input  logic                           last_byte,
   input  logic                           empty_code,
   input  bpv_pkg::cfg_type               cfg,
   output bpv_pkg::result_type            result
);
   import bpv_pkg::*;

   typedef enum logic [1:0] {
      PH_OPCODE = 2'd0,
      PH_SIZE   = 2'd1,
      PH_SKIP   = 2'd2
   } phase_type;

   phase_type          phase_ff, phase_in, phase_upd;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SKIP_W-1:0]  skip_ff, skip_in, skip_upd, skip_dec;
   logic [POS_W-1:0]   push_ff, push_in, push_upd;
   verdict_type        err_ff, err_in, err_upd;
   logic [POS_W-1:0]   err_pos_ff, err_pos_in, err_pos_upd;
   logic               take;
   logic               done;

   assign take     = step && !empty_code;
   assign done     = step && (empty_code || last_byte);
   assign skip_dec = (skip_ff != '0) ? skip_ff - 1'b1 : skip_ff;

   always_comb begin
      phase_upd   = phase_ff;
      skip_upd    = skip_ff;
      push_upd    = push_ff;
      err_upd     = err_ff;
      err_pos_upd = err_pos_ff;
      count_upd_blk: begin
         count_in = (take && count_ff != COUNT_SAT) ? count_ff + 1'b1 : count_ff;
      end
      if (take && err_ff == V_OK) begin
         case (phase_ff)
            PH_SIZE: begin
               if (code_byte == '0 || code_byte > CODE_W'(PUSH_MAX_SIZE)) begin
                  err_upd     = V_BAD_PUSH_SIZE;
                  err_pos_upd = push_ff;
                  phase_upd   = PH_OPCODE;
               end else begin
                  skip_upd  = code_byte[SKIP_W-1:0];
                  phase_upd = PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_upd  = skip_dec;
               phase_upd = (skip_dec == '0) ? PH_OPCODE : PH_SKIP;
            end
            default: begin
               if (!cfg.valid_mask[code_byte]) begin
                  err_upd     = V_BAD_OP;
                  err_pos_upd = count_ff[POS_W-1:0];
               end else if (code_byte == cfg.push_opcode) begin
                  push_upd  = count_ff[POS_W-1:0];
                  phase_upd = PH_SIZE;
               end
            end
         endcase
      end
   end

   always_comb begin
      result.done     = done;
      result.verdict  = V_OK;
      result.position = '0;
      if (count_in == '0) begin
         result.verdict = V_EMPTY;
      end else if (count_in > cfg.limit) begin
         result.verdict = V_TOO_LONG;
      end else if (err_upd != V_OK) begin
         result.verdict  = err_upd;
         result.position = err_pos_upd;
      end else if (phase_upd == PH_SIZE) begin
         result.verdict  = V_PUSH_NO_SIZE;
         result.position = push_upd;
      end else if (phase_upd == PH_SKIP) begin
         result.verdict  = V_PUSH_OVERRUN;
         result.position = push_upd;
      end
   end

   always_comb begin
      if (done) begin
         phase_in   = PH_OPCODE;
         skip_in    = '0;
         push_in    = '0;
         err_in     = V_OK;
         err_pos_in = '0;
      end else begin
         phase_in   = phase_upd;
         skip_in    = skip_upd;
         push_in    = push_upd;
         err_in     = err_upd;
         err_pos_in = err_pos_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPCODE;
         count_ff   <= '0;
         skip_ff    <= '0;
         push_ff    <= '0;
         err_ff     <= V_OK;
         err_pos_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= done ? '0 : count_in;
         skip_ff    <= skip_in;
         push_ff    <= push_in;
         err_ff     <= err_in;
         err_pos_ff <= err_pos_in;
      end
   end

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      done |=> count_ff == '0)
      else $error("byte count not cleared after the end of the code");

   a_skip_bound: assert property (@(posedge clock) disable iff (reset)
      skip_ff <= PUSH_MAX_SIZE)
      else $error("skip count beyond the largest push size");

   a_skip_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != '0)
      else $error("skipping data with nothing left to skip");

   a_error_held: assert property (@(posedge clock) disable iff (reset)
      (err_ff != V_OK && !done) |=> $stable(err_ff) && $stable(err_pos_ff))
      else $error("first error overwritten before the end of the code");

endmodule

FILE: sv/bytecode_push_validator.sv
`timescale 1ns / 1ps

// Channel  Ports       Direction  Contents
// request  req_chan    in         code_byte, last_byte, empty_code
// result   rsp_chan    out        verdict, error_position
// config   csr_chan    in         index, data (valid masks, push opcode, length limit)
//
// One request is taken every cycle unless the input register is full and the result
// stalled; its result, if it ends the code, goes from there to the output register.
// Reset is synchronous and returns the masks, push opcode, limit and parse state to
// their defaults. A stalled result stalls the input register only while it is full.

module bytecode_push_validator #(
   parameter int unsigned MAX_LEN = 65536
) (
   input logic      clock,
   input logic      reset,
   bpv_req_if.sink  req_chan,
   bpv_rsp_if.source rsp_chan,
   bpv_csr_if.sink  csr_chan
);
   import bpv_pkg::*;

   localparam logic [COUNT_W-1:0] LIMIT_CAP =
      (MAX_LEN < 131070) ? COUNT_W'(MAX_LEN) : LIMIT_HARD;

   logic [MASK_W-1:0]  mask_ff;
   logic [CODE_W-1:0]  push_op_ff;
   logic [COUNT_W-1:0] max_len_ff;

   logic               in_valid_ff, in_valid_in;
   logic [CODE_W-1:0]  in_byte_ff;
   logic               in_last_ff;
   logic               in_empty_ff;

   logic               out_valid_ff, out_valid_in;
   verdict_type        out_verdict_ff;
   logic [POS_W-1:0]   out_pos_ff;

   logic               move;
   logic               step;
   logic               req_take;
   cfg_type            cfg;
   result_type         result;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= '0;
         push_op_ff <= '0;
         max_len_ff <= 17'h10000;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_VALID_MASK_0: mask_ff[0*CSR_DATA_W +: CSR_DATA_W] <= csr_chan.data;
            CSR_VALID_MASK_1: mask_ff[1*CSR_DATA_W +: CSR_DATA_W] <= csr_chan.data;
            CSR_VALID_MASK_2: mask_ff[2*CSR_DATA_W +: CSR_DATA_W] <= csr_chan.data;
            CSR_VALID_MASK_3: mask_ff[3*CSR_DATA_W +: CSR_DATA_W] <= csr_chan.data;
            CSR_PUSH_OPCODE:  push_op_ff <= csr_chan.data[CODE_W-1:0];
            CSR_MAX_CODE_LEN: max_len_ff <= csr_chan.data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.valid_mask  = mask_ff;
   assign cfg.push_opcode = push_op_ff;
   assign cfg.limit       = (max_len_ff < LIMIT_CAP) ? max_len_ff : LIMIT_CAP;

   assign move           = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && move;
   assign req_chan.ready = !in_valid_ff || move;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in   = move ? (step && result.done) : out_valid_ff;

   bpv_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .code_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .empty_code (in_empty_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         in_byte_ff  <= req_chan.code_byte;
         in_last_ff  <= req_chan.last_byte;
         in_empty_ff <= req_chan.empty_code;
      end
      if (move) begin
         out_verdict_ff <= result.verdict;
         out_pos_ff     <= result.position;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.verdict        = out_verdict_ff;
   assign rsp_chan.error_position = out_pos_ff;

endmodule
